### hdl/msx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msx_pkg: shared types and constants for the MIPS subset execute core
// Transaction payloads, opcode and function codes, and the execute result
// record that moves from the execute stage to the memory stage.
// ----------------------------------------------------------------------------
package msx_pkg;

   localparam int DEF_DATA_WORDS = 1024;

   localparam int PC_W    = 16;
   localparam int WORD_W  = 32;
   localparam int REG_W   = 5;
   localparam int PROG_W  = 17;
   localparam int NUM_REGS = 32;

   localparam logic [PROG_W-1:0] PROG_WORDS_RST = 17'h10000;

   localparam logic [REG_W-1:0] LINK_REG = 5'd31;

   // action codes
   localparam logic ACT_PRELOAD = 1'b0;
   localparam logic ACT_EXEC    = 1'b1;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] instr_word;
      logic [9:0]        data_index;
      logic [WORD_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              reg_written;
      logic [REG_W-1:0]  dest_reg;
      logic [WORD_W-1:0] dest_value;
      logic              unknown_instr;
   } rsp_type;

   // execute stage result; dest_value is the ALU value, replaced by the
   // memory read data for loads
   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              reg_written;
      logic [REG_W-1:0]  dest_reg;
      logic [WORD_W-1:0] dest_value;
      logic              unknown_instr;
      logic              is_load;
      logic              load_ok;
   } exec_res_type;

endpackage
`default_nettype wire

### hdl/mips_subset_execute_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_core: MIPS32 integer subset execute core
// Register file, data memory and PC in a three-stage pipeline with operand
// forwarding; one transaction per clock while not stalled or clearing.
// ----------------------------------------------------------------------------
// Takes one transaction per clock (preload or execute) while req_ready is
// high, and returns one result per transaction, in order. Stages:
// register file read, execute plus data memory access, load data select
// into the output register. Register results are forwarded from the memory
// stage and the output register, so dependent instructions and loads issue
// back to back without stalls; only a full output register holds the
// pipeline. After reset the data memory is cleared one word per clock
// while req_ready stays low; csr writes are taken throughout.
module mips_subset_execute_core
   import msx_pkg::*;
#(
   parameter int DATA_WORDS = DEF_DATA_WORDS
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [PROG_W-1:0] csr_write_data
);

   localparam int AW = $clog2(DATA_WORDS);

   logic               adv, accept, dmem_busy;
   logic               s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   req_type            s1_item_ff;
   exec_res_type       exec_res, s2_res_ff;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [PC_W-1:0]    pc_ff;
   logic [PROG_W-1:0]  prog_words_ff;
   logic [WORD_W-1:0]  rf_a, rf_b, op_a, op_b, dmem_rdata, s2_value;
   logic [REG_W-1:0]   s1_rs, s1_rt;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic [WORD_W-1:0]  mem_wdata;
   logic               rf_we;

   // the whole pipeline moves together whenever the output register frees
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !dmem_busy;
   assign accept    = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_words_ff <= PROG_WORDS_RST;
      end else if (csr_write_en) begin
         prog_words_ff <= csr_write_data;
      end
   end

   // ---- register file read stage
   assign rf_we = adv && s2_valid_ff && s2_res_ff.reg_written;

   msx_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .ra_addr (req_data.instr_word[25:21]),
      .rb_addr (req_data.instr_word[20:16]),
      .ra_data (rf_a),
      .rb_data (rf_b),
      .wr_en   (rf_we),
      .wr_addr (s2_res_ff.dest_reg),
      .wr_data (s2_value)
   );

   // ---- execute stage
   assign s1_rs = s1_item_ff.instr_word[25:21];
   assign s1_rt = s1_item_ff.instr_word[20:16];

   // forward from the memory stage, then from the result that was written
   // at the same edge as our read
   always_comb begin
      if (s1_rs == '0) begin
         op_a = '0;
      end else if (s2_valid_ff && s2_res_ff.reg_written && s2_res_ff.dest_reg == s1_rs) begin
         op_a = s2_value;
      end else if (rsp_valid_ff && rsp_data_ff.reg_written
                   && rsp_data_ff.dest_reg == s1_rs) begin
         op_a = rsp_data_ff.dest_value;
      end else begin
         op_a = rf_a;
      end
      if (s1_rt == '0) begin
         op_b = '0;
      end else if (s2_valid_ff && s2_res_ff.reg_written && s2_res_ff.dest_reg == s1_rt) begin
         op_b = s2_value;
      end else if (rsp_valid_ff && rsp_data_ff.reg_written
                   && rsp_data_ff.dest_reg == s1_rt) begin
         op_b = rsp_data_ff.dest_value;
      end else begin
         op_b = rf_b;
      end
   end

   msx_exec #(
      .DATA_WORDS (DATA_WORDS)
   ) u_exec (
      .item          (s1_item_ff),
      .a             (op_a),
      .b             (op_b),
      .pc            (pc_ff),
      .program_words (prog_words_ff),
      .res           (exec_res),
      .mem_we        (mem_we),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata)
   );

   msx_dmem #(
      .DATA_WORDS (DATA_WORDS)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .busy    (dmem_busy),
      .rd_en   (adv),
      .wr_en   (adv && s1_valid_ff && mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (dmem_rdata)
   );

   // ---- memory stage: pick load data
   always_comb begin
      if (s2_res_ff.is_load) begin
         s2_value = s2_res_ff.load_ok ? dmem_rdata : '0;
      end else begin
         s2_value = s2_res_ff.dest_value;
      end
   end

   assign rsp_data_in.next_pc       = s2_res_ff.next_pc;
   assign rsp_data_in.reg_written   = s2_res_ff.reg_written;
   assign rsp_data_in.dest_reg      = s2_res_ff.dest_reg;
   assign rsp_data_in.dest_value    = s2_value;
   assign rsp_data_in.unknown_instr = s2_res_ff.unknown_instr;

   // ---- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) begin
            pc_ff <= exec_res.next_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff  <= req_data;
         s2_res_ff   <= exec_res;
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_pc_holds: assert property (@(posedge clock) disable iff (reset)
      !(adv && s1_valid_ff) |=> $stable(pc_ff))
      else $error("PC changed without a transaction leaving execute");

   a_no_reg0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (s2_res_ff.dest_reg != '0))
      else $error("register zero written");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      dmem_busy |-> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("transaction in flight during memory clear");

   a_unknown_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.unknown_instr && rsp_data.reg_written))
      else $error("unknown instruction wrote a register");
`endif

endmodule
`default_nettype wire

### hdl/msx_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msx_regfile: 32 x 32 register file
// Synchronous memory, one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module msx_regfile
   import msx_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [REG_W-1:0]  ra_addr,
   input  wire logic [REG_W-1:0]  rb_addr,
   output logic      [WORD_W-1:0] ra_data,
   output logic      [WORD_W-1:0] rb_data,
   input  wire logic              wr_en,
   input  wire logic [REG_W-1:0]  wr_addr,
   input  wire logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0]   mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [WORD_W-1:0]   ra_data_ff, rb_data_ff;
   logic                ra_valid_ff, rb_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ra_data_ff <= mem[ra_addr];
         rb_data_ff <= mem[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ra_valid_ff <= 1'b0;
         rb_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            // register zero never reads back stored data
            ra_valid_ff <= valid_ff[ra_addr] && (ra_addr != '0);
            rb_valid_ff <= valid_ff[rb_addr] && (rb_addr != '0);
         end
      end
   end

   assign ra_data = ra_valid_ff ? ra_data_ff : '0;
   assign rb_data = rb_valid_ff ? rb_data_ff : '0;

endmodule
`default_nettype wire

### hdl/msx_dmem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msx_dmem: word-addressed data memory
// Single-port synchronous memory with registered read data. After reset a
// clearing pass writes zero to every word, one word per cycle.
// ----------------------------------------------------------------------------
module msx_dmem
   import msx_pkg::*;
#(
   parameter int DATA_WORDS = DEF_DATA_WORDS
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   output logic                               busy,
   input  wire logic                          rd_en,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DATA_WORDS)-1:0] addr,
   input  wire logic [WORD_W-1:0]             wr_data,
   output logic      [WORD_W-1:0]             rd_data
);

   localparam int AW = $clog2(DATA_WORDS);
   localparam int CW = $clog2(DATA_WORDS + 1);

   logic [WORD_W-1:0] mem [DATA_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [CW-1:0]     clr_cnt_ff, clr_cnt_in;

   assign busy       = (clr_cnt_ff != CW'(DATA_WORDS));
   assign clr_cnt_in = clr_cnt_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (busy) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/msx_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msx_exec: decode and execute
// Decodes one transaction, computes the ALU result, next PC and the data
// memory access (address, write enable, write data).
// ----------------------------------------------------------------------------
module msx_exec
   import msx_pkg::*;
#(
   parameter int DATA_WORDS = DEF_DATA_WORDS
)
(
   input  wire req_type                        item,
   input  wire logic [WORD_W-1:0]              a,
   input  wire logic [WORD_W-1:0]              b,
   input  wire logic [PC_W-1:0]                pc,
   input  wire logic [PROG_W-1:0]              program_words,
   output exec_res_type                        res,
   output logic                                mem_we,
   output logic      [$clog2(DATA_WORDS)-1:0]  mem_addr,
   output logic      [WORD_W-1:0]              mem_wdata
);

   localparam int AW = $clog2(DATA_WORDS);

   logic [5:0]        op, fn;
   logic [REG_W-1:0]  rt, rd, sh;
   logic [WORD_W-1:0] iw, imm_sx, imm_zx, ea, mem_idx, val;
   logic [PC_W-1:0]   seq, npc;
   logic              idx_ok, wr, unk, is_load;
   logic [REG_W-1:0]  dest;

   assign iw     = item.instr_word;
   assign op     = iw[31:26];
   assign rt     = iw[20:16];
   assign rd     = iw[15:11];
   assign sh     = iw[10:6];
   assign fn     = iw[5:0];
   assign imm_sx = {{16{iw[15]}}, iw[15:0]};
   assign imm_zx = {16'd0, iw[15:0]};
   assign ea     = a + imm_sx;
   assign seq    = pc + PC_W'(1);

   always_comb begin
      if (item.action == ACT_PRELOAD) begin
         mem_idx = {22'd0, item.data_index};
      end else begin
         mem_idx = {2'b00, ea[31:2]};
      end
   end

   assign idx_ok    = (mem_idx < 32'(DATA_WORDS));
   assign mem_addr  = mem_idx[AW-1:0];
   assign mem_wdata = (item.action == ACT_PRELOAD) ? item.data_value : b;

   always_comb begin
      npc     = seq;
      wr      = 1'b0;
      dest    = rt;
      val     = '0;
      unk     = 1'b0;
      is_load = 1'b0;
      mem_we  = 1'b0;
      if (item.action == ACT_PRELOAD) begin
         npc    = pc;
         mem_we = idx_ok;
      end else if ({1'b0, pc} >= program_words) begin
         unk = 1'b1;
      end else begin
         case (op)
            OP_SPECIAL: begin
               dest = rd;
               wr   = 1'b1;
               case (fn)
                  FN_ADD, FN_ADDU: val = a + b;
                  FN_SUB, FN_SUBU: val = a - b;
                  FN_AND:          val = a & b;
                  FN_OR:           val = a | b;
                  FN_SLT:          val = {31'd0, ($signed(a) < $signed(b))};
                  FN_SLTU:         val = {31'd0, (a < b)};
                  FN_SLL:          val = b << sh;
                  FN_SRL:          val = b >> sh;
                  FN_JR: begin
                     wr  = 1'b0;
                     npc = a[17:2];
                  end
                  default: begin
                     wr  = 1'b0;
                     unk = 1'b1;
                  end
               endcase
            end
            OP_J:   npc = iw[15:0];
            OP_JAL: begin
               npc  = iw[15:0];
               wr   = 1'b1;
               dest = LINK_REG;
               val  = {16'd0, seq};
            end
            OP_BEQ: if (a == b) npc = seq + imm_sx[15:0];
            OP_BNE: if (a != b) npc = seq + imm_sx[15:0];
            OP_ADDI, OP_ADDIU: begin
               wr  = 1'b1;
               val = a + imm_sx;
            end
            OP_SLTI: begin
               wr  = 1'b1;
               val = {31'd0, ($signed(a) < $signed(imm_sx))};
            end
            OP_SLTIU: begin
               wr  = 1'b1;
               val = {31'd0, (a < imm_sx)};
            end
            OP_ANDI: begin
               wr  = 1'b1;
               val = a & imm_zx;
            end
            OP_ORI: begin
               wr  = 1'b1;
               val = a | imm_zx;
            end
            OP_LUI: begin
               wr  = 1'b1;
               val = {iw[15:0], 16'd0};
            end
            OP_LW: begin
               wr      = 1'b1;
               is_load = 1'b1;
            end
            OP_SW:  mem_we = idx_ok;
            default: unk = 1'b1;
         endcase
      end

      // writes to register zero are dropped and reported as no write
      if (!wr || dest == '0) begin
         wr      = 1'b0;
         dest    = '0;
         val     = '0;
         is_load = 1'b0;
      end
   end

   assign res.next_pc       = npc;
   assign res.reg_written   = wr;
   assign res.dest_reg      = dest;
   assign res.dest_value    = val;
   assign res.unknown_instr = unk;
   assign res.is_load       = is_load;
   assign res.load_ok       = idx_ok;

endmodule
`default_nettype wire
